FILE: src/mhpq_pkg.sv
// Shared types and constants for the min-heap priority queue.
package mhpq_pkg;

  localparam int unsigned DEF_CAPACITY = 64;
  localparam int unsigned ValueW       = 32;
  localparam int unsigned EntryCountW  = 7;

  typedef logic signed [ValueW-1:0] value_t;

  // Operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam value_t EMPTY_VALUE = -32'sd1;

  typedef struct packed {
    logic   opcode;
    value_t value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]             status;
    value_t                 min_value;
    logic [EntryCountW-1:0] entry_count;
  } out_item_t;

  // Broadcast to every cell of the chain
  typedef struct packed {
    logic   ins;
    logic   del;
    value_t value;
  } cell_cmd_t;

  // What a cell shows its neighbours
  typedef struct packed {
    logic   occ;
    logic   gt;
    value_t value;
  } cell_nbr_t;

endpackage

FILE: src/mhpq_cell.sv
// One cell of the sorted chain: holds one entry and its occupied flag.
module mhpq_cell
  import mhpq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_cmd_t cmd_i,
  input  cell_nbr_t prev_i,
  input  cell_nbr_t next_i,
  output cell_nbr_t self_o
);

  logic   occ_q, occ_d;
  value_t val_q, val_d;
  logic   gt;
  logic   take;

  // new value sorts strictly before the one held here
  assign gt = occ_q && (cmd_i.value < val_q);

  always_comb begin
    occ_d = occ_q;
    val_d = val_q;
    take  = occ_q ? gt : prev_i.occ;
    if (cmd_i.ins) begin
      if (take) begin
        occ_d = 1'b1;
        val_d = prev_i.gt ? prev_i.value : cmd_i.value;
      end
    end else if (cmd_i.del) begin
      occ_d = next_i.occ;
      val_d = next_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign self_o = '{occ: occ_q, gt: gt, value: val_q};

endmodule

FILE: src/min_heap_priority_queue.sv
// Top level: priority queue built as a sorted chain of cells.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------
//  in      | input     | in_valid_i/in_ready_o   | in_item_i  (in_item_t)
//  out     | output    | out_valid_o/out_ready_i | out_item_o (out_item_t)
//
// One item per clock unless stalled; its result is in the output register the
// cycle after acceptance. Every cell compares against the new value in the same
// cycle, so the delay does not grow with CAPACITY. The chain keeps the smallest
// entry in the first cell. Reset empties the chain at once, no clearing pass.
// in_ready_o drops only while a result waits and out_ready_i is low.
module min_heap_priority_queue
  import mhpq_pkg::*;
#(
  parameter int unsigned CAPACITY = DEF_CAPACITY
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic            accept;
  logic            out_valid_q;
  out_item_t       out_item_q, out_item_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            empty, full;
  cell_cmd_t       cmd;
  cell_nbr_t       nbr [CAPACITY];
  logic [CAPACITY-1:0] occ;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign empty = !nbr[0].occ;
  assign full  = nbr[CAPACITY-1].occ;

  assign cmd.value = in_item_i.value;
  assign cmd.ins   = accept && (in_item_i.opcode == OP_INSERT) && !full;
  assign cmd.del   = accept && (in_item_i.opcode == OP_REMOVE) && !empty;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_nbr_t prev, next;
    if (i == 0) begin : g_head
      assign prev = '{occ: 1'b1, gt: 1'b0, value: '0};
    end else begin : g_body
      assign prev = nbr[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign next = '{occ: 1'b0, gt: 1'b0, value: nbr[i].value};
    end else begin : g_mid
      assign next = nbr[i+1];
    end
    assign occ[i] = nbr[i].occ;

    mhpq_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd),
      .prev_i (prev),
      .next_i (next),
      .self_o (nbr[i])
    );
  end

  always_comb begin
    cnt_d      = cnt_q;
    out_item_d = out_item_q;
    if (accept) begin
      if (in_item_i.opcode == OP_INSERT) begin
        out_item_d.min_value = '0;
        if (full) begin
          out_item_d.status = ST_FULL;
        end else begin
          out_item_d.status = ST_OK;
          cnt_d             = cnt_q + CntW'(1);
        end
      end else begin
        if (empty) begin
          out_item_d.status    = ST_EMPTY;
          out_item_d.min_value = EMPTY_VALUE;
        end else begin
          out_item_d.status    = ST_OK;
          out_item_d.min_value = nbr[0].value;
          cnt_d                = cnt_q - CntW'(1);
        end
      end
      // count field is narrower than the counter for large capacities
      out_item_d.entry_count = EntryCountW'(cnt_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // occupied cells always form an unbroken run from the head
  a_occ_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ & (occ + 1'b1)) == '0)
    else $error("occupied cells not contiguous");

  a_cnt_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(occ) == int'(cnt_q))
    else $error("entry count disagrees with chain");

  a_remove_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.del |=> (out_item_o.min_value == $past(nbr[0].value)))
    else $error("removed value is not the head entry");

  a_head_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ[0] && (CAPACITY > 1) && occ[CAPACITY > 1 ? 1 : 0])
      |-> !(nbr[CAPACITY > 1 ? 1 : 0].value < nbr[0].value))
    else $error("head entry is not the smallest");

endmodule
